/* rtl/fcs_pkg.sv */
// Package for the flash command sequencer: request and response types,
// array geometry, command constants and lane address helpers.
// No dependencies.
`timescale 1ns / 1ps

package fcs_pkg;

  localparam int unsigned ARRAY_BYTES  = 131072;
  localparam int unsigned SECTOR_BYTES = 16384;
  localparam int unsigned ADDR_W       = 17;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned LANES        = 4;
  localparam int unsigned WORDS        = ARRAY_BYTES / LANES;
  localparam int unsigned WORD_W       = $clog2(WORDS);
  localparam int unsigned SECTOR_WORDS = SECTOR_BYTES / LANES;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 17'h05555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 17'h02aaa;
  localparam logic [DATA_W-1:0] UNLOCK_DATA1     = 32'h0000_00aa;
  localparam logic [DATA_W-1:0] UNLOCK_DATA2     = 32'h0000_0055;
  localparam logic [DATA_W-1:0] CMD_ERASE        = 32'h0000_0080;
  localparam logic [DATA_W-1:0] CMD_ERASE_CHIP   = 32'h0000_0010;
  localparam logic [DATA_W-1:0] CMD_ERASE_SECTOR = 32'h0000_0030;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 32'h0000_00a0;
  localparam logic [7:0]        ERASED_BYTE      = 8'hff;

  localparam logic       REQ_READ     = 1'b0;
  localparam logic       REQ_WRITE    = 1'b1;
  localparam logic [1:0] SIZE_BYTE    = 2'd0;
  localparam logic [1:0] SIZE_HALF    = 2'd1;
  localparam logic [1:0] SIZE_WORD    = 2'd2;
  localparam logic [1:0] SIZE_INVALID = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [1:0]        access_size;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              status;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_PROG,
    OP_ERASE_CHIP,
    OP_ERASE_SECTOR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              err;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic [2:0]        len;
  } entry_t;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_GOT_AA   = 3'd1,
    STEP_GOT_55   = 3'd2,
    STEP_ARMED    = 3'd3,
    STEP_ERASE_AA = 3'd4,
    STEP_ERASE_55 = 3'd5
  } step_e;

  typedef enum logic [1:0] {
    BK_ERASE,
    BK_IDLE,
    BK_ACCESS
  } bk_state_e;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  function automatic logic [1:0] lane_offset(logic [ADDR_W-1:0] a, logic [1:0] lane);
    return lane - a[1:0];
  endfunction

  function automatic logic [WORD_W-1:0] lane_word(logic [ADDR_W-1:0] a, logic [1:0] lane);
    logic [31:0] b;
    b = 32'(a) + 32'(lane_offset(a, lane));
    b = b >> 2;
    return b[WORD_W-1:0];
  endfunction

  function automatic logic in_range(logic [31:0] base, logic [31:0] len);
    return (base + len) <= 32'(ARRAY_BYTES);
  endfunction

endpackage

/* rtl/flash_command_sequencer_core.sv */
// Top level of the flash command sequencer: front end, queue and back end.
// Uses fcs_pkg, fcs_front, fcs_queue and fcs_back.
//
// A transaction is accepted at a rising edge where start_i is high and busy_o
// is low; req_i carries the access type, byte address, write data and size.
// Each accepted transaction produces exactly one response on rsp_o, valid for
// the single cycle in which done_o is high. Responses come back in order.
// The front end checks the unlock/command sequence at acceptance and pushes
// a classified entry into a two-entry queue; busy_o is high while that queue
// is full. The back end owns four byte-lane RAMs with registered reads.
// A read or program passes through the queue, the back-end access state and
// the response register; sequence steps and errors skip the access state.
// The back end takes one read or program at a time: the RAM read, then the
// response (and write-back) step, before it takes the next entry.
// A sector or chip erase occupies the back end while it writes one word of
// all lanes per cycle over the sector or the whole array.
// After reset the back end fills the whole array with 0xff, and busy_o
// stays high until it is done.
// The receiver cannot stall; a response must be taken in its cycle.
`timescale 1ns / 1ps

module flash_command_sequencer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  fcs_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output fcs_pkg::rsp_t rsp_o
);

  logic                accept;
  fcs_pkg::entry_t     entry;
  fcs_pkg::entry_t     q_head;
  logic                q_empty;
  logic                q_full;
  logic                q_pop;
  fcs_pkg::bk_status_t bk_sts;

  assign busy_o = q_full | bk_sts.clearing;
  assign accept = start_i & ~busy_o;

  fcs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .entry_o  (entry)
  );

  fcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fcs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .status_o  (bk_sts)
  );

`ifndef SYNTHESIS
  a_no_rsp_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_sts.clearing |-> !done_o)
    else $error("Response issued during the initial array fill.");

  a_err_rsp_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |-> (rsp_o.read_data == '0))
    else $error("Flagged response carries nonzero read data.");

  a_clear_only_after_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$rose(bk_sts.clearing))
    else $error("Array fill restarted outside of reset.");
`endif

endmodule

/* rtl/fcs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/fcs_front.sv */
// Front end of the flash command sequencer: tracks the unlock and command
// sequence and classifies each transaction into a queue entry. Uses fcs_pkg.
`timescale 1ns / 1ps

module fcs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  fcs_pkg::req_t  req_i,
  output fcs_pkg::entry_t entry_o
);

  fcs_pkg::step_e step_q, step_d;
  logic           pend_q, pend_d;

  logic [31:0]    data_m;
  logic [2:0]     len;
  logic           size_ok;
  logic           rng_ok;
  logic           sect_ok;
  logic [31:0]    sect_base;

  fcs_pkg::op_e   op_c;
  logic           err_c;
  fcs_pkg::step_e tgt_c;
  logic           pend_c;

  always_comb begin
    size_ok = 1'b1;
    len     = 3'd0;
    data_m  = req_i.write_data;
    case (req_i.access_size)
      fcs_pkg::SIZE_BYTE: begin
        len    = 3'd1;
        data_m = req_i.write_data & 32'h0000_00ff;
      end
      fcs_pkg::SIZE_HALF: begin
        len    = 3'd2;
        data_m = req_i.write_data & 32'h0000_ffff;
      end
      fcs_pkg::SIZE_WORD: begin
        len = 3'd4;
      end
      default: begin
        size_ok = 1'b0;
      end
    endcase
  end

  assign rng_ok    = fcs_pkg::in_range(32'(req_i.address), 32'(len));
  assign sect_base = 32'(req_i.address) & ~32'(fcs_pkg::SECTOR_BYTES - 1);
  assign sect_ok   = fcs_pkg::in_range(sect_base, 32'(fcs_pkg::SECTOR_BYTES));

  always_comb begin
    op_c   = fcs_pkg::OP_NONE;
    err_c  = 1'b0;
    tgt_c  = step_q;
    pend_c = pend_q;
    if (!size_ok) begin
      err_c = 1'b1;
    end else if (req_i.req_type == fcs_pkg::REQ_READ) begin
      if ((step_q != fcs_pkg::STEP_IDLE) || !rng_ok) begin
        err_c = 1'b1;
      end else begin
        op_c = fcs_pkg::OP_READ;
      end
    end else begin
      case (step_q)
        fcs_pkg::STEP_IDLE, fcs_pkg::STEP_ARMED: begin
          if ((step_q == fcs_pkg::STEP_ARMED) && pend_q) begin
            if (!rng_ok) begin
              err_c = 1'b1;
            end else begin
              op_c  = fcs_pkg::OP_PROG;
              tgt_c = fcs_pkg::STEP_IDLE;
            end
          end else if ((req_i.address == fcs_pkg::UNLOCK_ADDR1) &&
                       (data_m == fcs_pkg::UNLOCK_DATA1)) begin
            tgt_c = (step_q == fcs_pkg::STEP_IDLE) ? fcs_pkg::STEP_GOT_AA
                                                   : fcs_pkg::STEP_ERASE_AA;
          end else begin
            err_c = 1'b1;
          end
        end
        fcs_pkg::STEP_GOT_AA, fcs_pkg::STEP_ERASE_AA: begin
          if ((req_i.address == fcs_pkg::UNLOCK_ADDR2) &&
              (data_m == fcs_pkg::UNLOCK_DATA2)) begin
            tgt_c = (step_q == fcs_pkg::STEP_GOT_AA) ? fcs_pkg::STEP_GOT_55
                                                     : fcs_pkg::STEP_ERASE_55;
          end else begin
            err_c = 1'b1;
          end
        end
        fcs_pkg::STEP_GOT_55: begin
          if ((req_i.address == fcs_pkg::UNLOCK_ADDR1) &&
              (data_m inside {fcs_pkg::CMD_ERASE, fcs_pkg::CMD_PROGRAM})) begin
            pend_c = (data_m == fcs_pkg::CMD_PROGRAM);
            tgt_c  = fcs_pkg::STEP_ARMED;
          end else begin
            err_c = 1'b1;
          end
        end
        fcs_pkg::STEP_ERASE_55: begin
          if ((data_m == fcs_pkg::CMD_ERASE_CHIP) &&
              (req_i.address == fcs_pkg::UNLOCK_ADDR1)) begin
            op_c  = fcs_pkg::OP_ERASE_CHIP;
            tgt_c = fcs_pkg::STEP_IDLE;
          end else if (data_m == fcs_pkg::CMD_ERASE_SECTOR) begin
            if (!sect_ok) begin
              err_c = 1'b1;
            end else begin
              op_c  = fcs_pkg::OP_ERASE_SECTOR;
              tgt_c = fcs_pkg::STEP_IDLE;
            end
          end else begin
            err_c = 1'b1;
          end
        end
        default: begin
          err_c = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    step_d = step_q;
    pend_d = pend_q;
    if (accept_i) begin
      if (err_c) begin
        step_d = fcs_pkg::STEP_IDLE;
      end else begin
        step_d = tgt_c;
        pend_d = pend_c;
      end
    end
  end

  always_comb begin
    entry_o.op      = op_c;
    entry_o.err     = err_c;
    entry_o.address = req_i.address;
    entry_o.data    = data_m;
    entry_o.len     = len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= fcs_pkg::STEP_IDLE;
      pend_q <= 1'b0;
    end else begin
      step_q <= step_d;
      pend_q <= pend_d;
    end
  end

endmodule

/* rtl/fcs_queue.sv */
// Short register queue between the front end and the back end of the
// flash command sequencer. Uses fcs_pkg.
`timescale 1ns / 1ps

module fcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fcs_pkg::entry_t entry_i,
  input  logic            pop_i,
  output fcs_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  fcs_pkg::entry_t              mem_q [fcs_pkg::QUEUE_DEPTH];
  logic [fcs_pkg::QPTR_W-1:0]   wr_q, wr_d;
  logic [fcs_pkg::QPTR_W-1:0]   rd_q, rd_d;
  logic [fcs_pkg::QCNT_W-1:0]   cnt_q, cnt_d;

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == fcs_pkg::QCNT_W'(fcs_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == fcs_pkg::QPTR_W'(fcs_pkg::QUEUE_DEPTH - 1)) ? '0
             : wr_q + fcs_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == fcs_pkg::QPTR_W'(fcs_pkg::QUEUE_DEPTH - 1)) ? '0
             : rd_q + fcs_pkg::QPTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + fcs_pkg::QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - fcs_pkg::QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/fcs_back.sv */
// Back end of the flash command sequencer: carries out reads, programs and
// erases on four byte-lane RAMs and returns one response per transaction.
// Uses fcs_pkg and fcs_ram.
`timescale 1ns / 1ps

module fcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  fcs_pkg::entry_t     q_head_i,
  output logic                q_pop_o,
  output logic                done_o,
  output fcs_pkg::rsp_t       rsp_o,
  output fcs_pkg::bk_status_t status_o
);

  localparam int unsigned WW = fcs_pkg::WORD_W;

  fcs_pkg::bk_state_e state_q, state_d;
  logic [WW-1:0]      cnt_q, cnt_d;
  logic [WW-1:0]      last_q, last_d;
  logic               report_q, report_d;
  fcs_pkg::entry_t    cur_q, cur_d;
  logic               done_q, done_d;
  fcs_pkg::rsp_t      rsp_q, rsp_d;

  logic          lane_we    [fcs_pkg::LANES];
  logic [WW-1:0] lane_waddr [fcs_pkg::LANES];
  logic [7:0]    lane_wdata [fcs_pkg::LANES];
  logic [WW-1:0] lane_raddr [fcs_pkg::LANES];
  logic [7:0]    lane_rdata [fcs_pkg::LANES];
  logic          lane_used  [fcs_pkg::LANES];
  logic [7:0]    prog_byte  [fcs_pkg::LANES];
  logic [31:0]   rd_word;
  logic [WW-1:0] sect_word;

  function automatic logic [WW-1:0] sector_first_word(logic [fcs_pkg::ADDR_W-1:0] a);
    logic [31:0] b;
    b = (32'(a) & ~32'(fcs_pkg::SECTOR_BYTES - 1)) >> 2;
    return b[WW-1:0];
  endfunction

  assign sect_word = sector_first_word(q_head_i.address);

  for (genvar l = 0; l < fcs_pkg::LANES; l++) begin : g_lane
    logic [1:0] off;
    assign off           = fcs_pkg::lane_offset(cur_q.address, 2'(l));
    assign lane_used[l]  = ({1'b0, off} < cur_q.len);
    assign prog_byte[l]  = cur_q.data[{off, 3'b000} +: 8];
    assign lane_raddr[l] = fcs_pkg::lane_word(q_head_i.address, 2'(l));
    assign lane_waddr[l] = (state_q == fcs_pkg::BK_ACCESS)
                           ? fcs_pkg::lane_word(cur_q.address, 2'(l)) : cnt_q;

    fcs_ram #(
      .WIDTH (8),
      .DEPTH (fcs_pkg::WORDS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lane_we[l]),
      .waddr_i (lane_waddr[l]),
      .wdata_i (lane_wdata[l]),
      .raddr_i (lane_raddr[l]),
      .rdata_o (lane_rdata[l])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < cur_q.len) begin
        rd_word[8*i +: 8] = lane_rdata[2'(cur_q.address[1:0] + 2'(i))];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    report_d = report_q;
    cur_d    = cur_q;
    case (state_q)
      fcs_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          cur_d = q_head_i;
          case (q_head_i.op)
            fcs_pkg::OP_READ, fcs_pkg::OP_PROG: begin
              state_d = fcs_pkg::BK_ACCESS;
            end
            fcs_pkg::OP_ERASE_CHIP: begin
              cnt_d    = '0;
              last_d   = WW'(fcs_pkg::WORDS - 1);
              report_d = 1'b1;
              state_d  = fcs_pkg::BK_ERASE;
            end
            fcs_pkg::OP_ERASE_SECTOR: begin
              cnt_d    = sect_word;
              last_d   = sect_word + WW'(fcs_pkg::SECTOR_WORDS - 1);
              report_d = 1'b1;
              state_d  = fcs_pkg::BK_ERASE;
            end
            default: begin
              state_d = fcs_pkg::BK_IDLE;
            end
          endcase
        end
      end
      fcs_pkg::BK_ACCESS: begin
        state_d = fcs_pkg::BK_IDLE;
      end
      fcs_pkg::BK_ERASE: begin
        if (cnt_q == last_q) begin
          state_d = fcs_pkg::BK_IDLE;
        end else begin
          cnt_d = cnt_q + WW'(1);
        end
      end
      default: begin
        state_d = fcs_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    for (int l = 0; l < fcs_pkg::LANES; l++) begin
      lane_we[l]    = 1'b0;
      lane_wdata[l] = fcs_pkg::ERASED_BYTE;
    end
    case (state_q)
      fcs_pkg::BK_IDLE: begin
        q_pop_o = !q_empty_i;
        if (!q_empty_i && (q_head_i.op == fcs_pkg::OP_NONE)) begin
          done_d          = 1'b1;
          rsp_d.read_data = '0;
          rsp_d.status    = q_head_i.err;
        end
      end
      fcs_pkg::BK_ACCESS: begin
        done_d       = 1'b1;
        rsp_d.status = 1'b0;
        if (cur_q.op == fcs_pkg::OP_PROG) begin
          rsp_d.read_data = '0;
          for (int l = 0; l < fcs_pkg::LANES; l++) begin
            lane_we[l]    = lane_used[l];
            lane_wdata[l] = lane_rdata[l] & prog_byte[l];
          end
        end else begin
          rsp_d.read_data = rd_word;
        end
      end
      fcs_pkg::BK_ERASE: begin
        for (int l = 0; l < fcs_pkg::LANES; l++) begin
          lane_we[l] = 1'b1;
        end
        if ((cnt_q == last_q) && report_q) begin
          done_d          = 1'b1;
          rsp_d.read_data = '0;
          rsp_d.status    = 1'b0;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fcs_pkg::BK_ERASE;
      cnt_q    <= '0;
      last_q   <= WW'(fcs_pkg::WORDS - 1);
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      last_q   <= last_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  assign done_o            = done_q;
  assign rsp_o             = rsp_q;
  assign status_o.clearing = (state_q == fcs_pkg::BK_ERASE) && !report_q;

endmodule
